### sv/olcu_pkg.sv
// Shared types and constants for the log-odds occupancy cell update unit.
// Holds the request and result structs, mode and register codes, and the neighbour table.
// No dependencies.
package olcu_pkg;

    typedef enum logic [2:0] {
        MODE_HIT    = 3'd0,
        MODE_MISS   = 3'd1,
        MODE_LOAD   = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_QUERY  = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        REG_HIT_INC    = 3'd0,
        REG_MISS_INC   = 3'd1,
        REG_CEILING    = 3'd2,
        REG_OCC_THR    = 3'd3,
        REG_FREE_THR   = 3'd4,
        REG_HITS_CONF  = 3'd5,
        REG_CONF_EN    = 3'd6
    } cfg_reg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [14:0]        HIT_INC_RST   = 15'd256;
    localparam logic signed [15:0] MISS_INC_RST  = -16'sd128;
    localparam logic signed [15:0] CEILING_RST   = 16'sd1280;
    localparam logic signed [15:0] OCC_THR_RST   = 16'sd512;
    localparam logic signed [15:0] FREE_THR_RST  = -16'sd256;
    localparam logic [7:0]         HITS_CONF_RST = 8'd3;
    localparam logic               CONF_EN_RST   = 1'b1;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
    } olcu_in_t;

    typedef struct packed {
        logic               cell_present;
        logic               cell_confirmed;
        logic               obstacle_flag;
        logic signed [15:0] cell_log_odds;
        logic [7:0]         cell_hits;
        logic               cell_removed;
    } olcu_out_t;

    // Classified request as it sits in the queue between front and back.
    typedef struct packed {
        mode_t      op;
        logic       in_grid;
        logic [7:0] x;
        logic [7:0] y;
    } cmd_t;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        STEP_NEG  = 2'd0,
        STEP_ZERO = 2'd1,
        STEP_POS  = 2'd2
    } step_t;

    localparam int NB_COUNT = 8;

    localparam step_t NB_DX [NB_COUNT] = '{STEP_NEG, STEP_ZERO, STEP_POS, STEP_NEG,
                                           STEP_POS, STEP_NEG, STEP_ZERO, STEP_POS};
    localparam step_t NB_DY [NB_COUNT] = '{STEP_NEG, STEP_NEG, STEP_NEG, STEP_ZERO,
                                           STEP_ZERO, STEP_POS, STEP_POS, STEP_POS};

endpackage

### sv/olcu_front.sv
// Front end: accepts requests, classifies mode and grid range, and queues them.
// Depends on olcu_pkg.
module olcu_front import olcu_pkg::*; #(
    parameter int GRID_SIDE = 256
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  olcu_in_t s_data,
    input  logic     clearing,
    output logic     q_valid,
    output cmd_t     q_cmd,
    input  logic     q_pop
);

    localparam int QW = $clog2(QUEUE_DEPTH);

    cmd_t          fifo_reg [QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg;
    logic [QW-1:0] rd_ptr_reg;
    logic [QW:0]   count_reg;
    cmd_t          cmd_in;
    logic          push;

    always_comb begin
        cmd_in.x = s_data.cell_x;
        cmd_in.y = s_data.cell_y;
        cmd_in.in_grid = (int'(s_data.cell_x) < GRID_SIDE) && (int'(s_data.cell_y) < GRID_SIDE);
        unique case (s_data.mode)
            MODE_HIT:    cmd_in.op = MODE_HIT;
            MODE_MISS:   cmd_in.op = MODE_MISS;
            MODE_LOAD:   cmd_in.op = MODE_LOAD;
            MODE_REMOVE: cmd_in.op = MODE_REMOVE;
            default:     cmd_in.op = MODE_QUERY;
        endcase
    end

    assign s_ready = !clearing && (count_reg != (QW+1)'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QW'(1);
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QW'(1);
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + (QW+1)'(1);
            end else if (!push && q_pop) begin
                count_reg <= count_reg - (QW+1)'(1);
            end
        end
    end

endmodule

### sv/olcu_back.sv
// Back end: cell store, configuration registers and the update sequencer.
// Reads the cell, updates it, scans neighbours when a confirm is possible, writes back.
// Depends on olcu_pkg.
module olcu_back import olcu_pkg::*; #(
    parameter int GRID_SIDE      = 256,
    parameter int LOG_ODDS_BITS  = 16,
    parameter int HIT_COUNT_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   q_valid,
    input  cmd_t                   q_cmd,
    output logic                   q_pop,
    output logic                   clearing,
    output logic                   m_valid,
    input  logic                   m_ready,
    output olcu_out_t              m_data
);

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int LB    = LOG_ODDS_BITS;
    localparam int HB    = HIT_COUNT_BITS;
    localparam int CELLW = 2 + HB + LB;
    localparam int WW    = ((LB > 16) ? LB : 16) + 2;

    localparam logic signed [WW-1:0] LO_MAX  = WW'((longint'(1) <<< (LB - 1)) - 1);
    localparam logic signed [WW-1:0] LO_MIN  = WW'(-(longint'(1) <<< (LB - 1)));
    localparam logic signed [WW-1:0] OUT_MAX = WW'(32767);
    localparam logic signed [WW-1:0] OUT_MIN = WW'(-32768);
    localparam logic [HB-1:0]        HIT_MAX = {HB{1'b1}};
    localparam logic [16:0]          HIT_MAX_W = 17'(HIT_MAX);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_CHECK,
        S_SCAN,
        S_WRITE
    } state_t;

    function automatic logic signed [LB-1:0] sat_lo(input logic signed [WW-1:0] v);
        logic signed [LB-1:0] r;
        if (v > LO_MAX) begin
            r = LO_MAX[LB-1:0];
        end else if (v < LO_MIN) begin
            r = LO_MIN[LB-1:0];
        end else begin
            r = v[LB-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [WW-1:0] ext_lo(input logic signed [LB-1:0] v);
        return {{(WW-LB){v[LB-1]}}, v};
    endfunction

    function automatic logic signed [WW-1:0] ext16(input logic [15:0] v);
        return {{(WW-16){v[15]}}, v};
    endfunction

    // Configuration registers
    logic [14:0]        hit_inc_reg;
    logic [15:0]        miss_inc_reg;
    logic [15:0]        ceiling_reg;
    logic [15:0]        occ_thr_reg;
    logic [15:0]        free_thr_reg;
    logic [7:0]         hits_conf_reg;
    logic               conf_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_inc_reg   <= HIT_INC_RST;
            miss_inc_reg  <= MISS_INC_RST;
            ceiling_reg   <= CEILING_RST;
            occ_thr_reg   <= OCC_THR_RST;
            free_thr_reg  <= FREE_THR_RST;
            hits_conf_reg <= HITS_CONF_RST;
            conf_en_reg   <= CONF_EN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_HIT_INC:   hit_inc_reg   <= cfg_wdata[14:0];
                REG_MISS_INC:  miss_inc_reg  <= cfg_wdata;
                REG_CEILING:   ceiling_reg   <= cfg_wdata;
                REG_OCC_THR:   occ_thr_reg   <= cfg_wdata;
                REG_FREE_THR:  free_thr_reg  <= cfg_wdata;
                REG_HITS_CONF: hits_conf_reg <= cfg_wdata[7:0];
                REG_CONF_EN:   conf_en_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Cell store: one write port, one registered read port.
    logic [CELLW-1:0] mem [DEPTH];
    logic [CELLW-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [CELLW-1:0] wr_data;
    logic             mem_we;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    state_t               state_reg;
    cmd_t                 cmd_reg;
    logic [CW-1:0]        cx_reg;
    logic [CW-1:0]        cy_reg;
    logic                 c_present_reg;
    logic                 c_conf_reg;
    logic [HB-1:0]        c_hits_reg;
    logic signed [LB-1:0] c_lo_reg;
    logic                 removed_reg;
    logic                 cand_reg;
    logic [3:0]           scan_idx_reg;
    logic                 chk_pend_reg;
    logic                 chk_in_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic                 out_valid_reg;
    olcu_out_t            out_data_reg;

    // Fields of the word just read
    logic                 rd_present;
    logic                 rd_conf;
    logic [HB-1:0]        rd_hits;
    logic signed [LB-1:0] rd_lo;

    assign rd_present = rd_data_reg[CELLW-1];
    assign rd_conf    = rd_data_reg[CELLW-2];
    assign rd_hits    = rd_data_reg[LB+HB-1:LB];
    assign rd_lo      = rd_data_reg[LB-1:0];

    // Update arithmetic for the addressed cell
    logic signed [WW-1:0] lo_w;
    logic signed [WW-1:0] hit_inc_w;
    logic signed [WW-1:0] ceil_w;
    logic signed [WW-1:0] occ_w;
    logic signed [LB-1:0] hit_sum_lo;
    logic signed [LB-1:0] hit_lo;
    logic signed [LB-1:0] miss_lo;
    logic signed [LB-1:0] load_lo;
    logic                 miss_free;
    logic [HB-1:0]        hits_inc;
    logic [16:0]          load_hits_w;
    logic [HB-1:0]        load_hits;
    logic                 calc_present;
    logic                 calc_conf;
    logic [HB-1:0]        calc_hits;
    logic signed [LB-1:0] calc_lo;
    logic                 calc_removed;
    logic                 calc_cand;

    always_comb begin
        lo_w        = ext_lo(rd_lo);
        hit_inc_w   = $signed({{(WW-15){1'b0}}, hit_inc_reg});
        ceil_w      = ext16(ceiling_reg);
        occ_w       = ext16(occ_thr_reg);
        hit_sum_lo  = sat_lo(lo_w + hit_inc_w);
        hit_lo      = (ext_lo(hit_sum_lo) > ceil_w) ? sat_lo(ceil_w) : hit_sum_lo;
        miss_lo     = sat_lo(lo_w + ext16(miss_inc_reg));
        miss_free   = ext_lo(miss_lo) < ext16(free_thr_reg);
        load_lo     = sat_lo(ceil_w);
        hits_inc    = (rd_hits == HIT_MAX) ? rd_hits : rd_hits + HB'(1);
        load_hits_w = 17'(hits_conf_reg) + 17'd1;
        load_hits   = (load_hits_w > HIT_MAX_W) ? HIT_MAX : load_hits_w[HB-1:0];

        calc_present = rd_present;
        calc_conf    = rd_conf;
        calc_hits    = rd_hits;
        calc_lo      = rd_lo;
        calc_removed = 1'b0;
        calc_cand    = 1'b0;
        unique case (cmd_reg.op)
            MODE_HIT: begin
                calc_present = 1'b1;
                if (!rd_present) begin
                    calc_conf = 1'b0;
                    calc_hits = HB'(1);
                    calc_lo   = sat_lo(hit_inc_w);
                end else begin
                    calc_hits = hits_inc;
                    calc_lo   = hit_lo;
                    calc_cand = !rd_conf;
                end
            end
            MODE_MISS: begin
                if (rd_present) begin
                    calc_lo      = miss_lo;
                    calc_removed = miss_free;
                end
            end
            MODE_LOAD: begin
                calc_present = 1'b1;
                calc_conf    = 1'b1;
                calc_hits    = load_hits;
                calc_lo      = load_lo;
            end
            MODE_REMOVE: begin
                calc_removed = rd_present;
            end
            default: ;
        endcase
        if (calc_removed) begin
            calc_present = 1'b0;
            calc_conf    = 1'b0;
            calc_hits    = '0;
            calc_lo      = '0;
        end
    end

    // Confirm precondition on the updated cell; the neighbour scan settles the rest.
    logic scan_needed;

    assign scan_needed = cand_reg && conf_en_reg
                      && (17'(c_hits_reg) >= 17'(hits_conf_reg))
                      && (ext_lo(c_lo_reg) >= ext16(occ_thr_reg));

    // Neighbour address for the current scan step
    logic [CW-1:0] nb_x;
    logic [CW-1:0] nb_y;
    logic          nb_ok_x;
    logic          nb_ok_y;
    logic [CW:0]   side_w;

    assign side_w = (CW+1)'(GRID_SIDE);

    always_comb begin
        nb_x    = cx_reg;
        nb_ok_x = 1'b1;
        unique case (NB_DX[scan_idx_reg[2:0]])
            STEP_NEG: begin
                nb_x    = cx_reg - CW'(1);
                nb_ok_x = (cx_reg != '0);
            end
            STEP_POS: begin
                nb_x    = cx_reg + CW'(1);
                nb_ok_x = ({1'b0, cx_reg} + (CW+1)'(1)) < side_w;
            end
            default: ;
        endcase
        nb_y    = cy_reg;
        nb_ok_y = 1'b1;
        unique case (NB_DY[scan_idx_reg[2:0]])
            STEP_NEG: begin
                nb_y    = cy_reg - CW'(1);
                nb_ok_y = (cy_reg != '0);
            end
            STEP_POS: begin
                nb_y    = cy_reg + CW'(1);
                nb_ok_y = ({1'b0, cy_reg} + (CW+1)'(1)) < side_w;
            end
            default: ;
        endcase
    end

    logic nb_found;
    logic scan_last;

    assign nb_found  = chk_pend_reg && chk_in_reg && rd_present && (17'(rd_hits) >= 17'd2);
    assign scan_last = (scan_idx_reg == 4'(NB_COUNT));

    // Result fields from the updated cell
    olcu_out_t            res;
    logic signed [WW-1:0] c_lo_w;
    logic [16:0]          c_hits_w;

    always_comb begin
        c_lo_w   = ext_lo(c_lo_reg);
        c_hits_w = 17'(c_hits_reg);
        res.cell_present   = c_present_reg;
        res.cell_confirmed = c_conf_reg;
        res.obstacle_flag  = c_conf_reg
                          || ((c_hits_w >= 17'd2) && ((c_lo_w <<< 1) >= ext16(occ_thr_reg)));
        if (c_lo_w > OUT_MAX) begin
            res.cell_log_odds = 16'sh7FFF;
        end else if (c_lo_w < OUT_MIN) begin
            res.cell_log_odds = 16'sh8000;
        end else begin
            res.cell_log_odds = c_lo_w[15:0];
        end
        res.cell_hits    = (c_hits_w > 17'd255) ? 8'hFF : c_hits_w[7:0];
        res.cell_removed = removed_reg;
    end

    logic out_free;
    logic out_load;

    assign out_free = !out_valid_reg || m_ready;
    assign out_load = (state_reg == S_WRITE) && out_free;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign clearing = (state_reg == S_CLEAR);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        unique case (state_reg)
            S_IDLE:  rd_addr = {CW'(q_cmd.y), CW'(q_cmd.x)};
            S_SCAN:  rd_addr = {nb_y, nb_x};
            default: rd_addr = {cy_reg, cx_reg};
        endcase
    end

    always_comb begin
        if (state_reg == S_CLEAR) begin
            mem_we  = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end else begin
            mem_we  = out_load && cmd_reg.in_grid;
            wr_addr = {cy_reg, cx_reg};
            wr_data = {c_present_reg, c_conf_reg, c_hits_reg, c_lo_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
            chk_pend_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == {AW{1'b1}}) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg     <= q_cmd;
                        cx_reg      <= CW'(q_cmd.x);
                        cy_reg      <= CW'(q_cmd.y);
                        removed_reg <= 1'b0;
                        if (q_cmd.in_grid) begin
                            state_reg <= S_CALC;
                        end else begin
                            // Outside the grid: all-zero result, store untouched.
                            c_present_reg <= 1'b0;
                            c_conf_reg    <= 1'b0;
                            c_hits_reg    <= '0;
                            c_lo_reg      <= '0;
                            state_reg     <= S_WRITE;
                        end
                    end
                end
                S_CALC: begin
                    c_present_reg <= calc_present;
                    c_conf_reg    <= calc_conf;
                    c_hits_reg    <= calc_hits;
                    c_lo_reg      <= calc_lo;
                    removed_reg   <= calc_removed;
                    cand_reg      <= calc_cand;
                    state_reg     <= S_CHECK;
                end
                S_CHECK: begin
                    scan_idx_reg <= '0;
                    chk_pend_reg <= 1'b0;
                    state_reg    <= scan_needed ? S_SCAN : S_WRITE;
                end
                S_SCAN: begin
                    // Reads are issued one step ahead of the check of their data.
                    if (nb_found) begin
                        c_conf_reg <= 1'b1;
                        state_reg  <= S_WRITE;
                    end else if (scan_last) begin
                        state_reg <= S_WRITE;
                    end else begin
                        chk_pend_reg <= 1'b1;
                        chk_in_reg   <= nb_ok_x && nb_ok_y;
                        scan_idx_reg <= scan_idx_reg + 4'd1;
                    end
                end
                S_WRITE: begin
                    if (out_free) begin
                        out_data_reg <= res;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### sv/occupancy_log_odds_cell_update_unit.sv
// Sequence: a queued request is taken, its cell read, updated and checked, and the result
// registered for output; a hit that can confirm first reads its neighbour cells in turn
// until one confirms it or all eight are read. The cell store and its read-update-write
// sequence take no new request before the last result is registered; a two-entry queue
// takes requests meanwhile. Reset: synchronous, active low; the store is cleared one cell
// per cycle, 2^(2*ceil(log2 GRID_SIDE)) cells (65536 by default), while s_ready stays low.
module occupancy_log_odds_cell_update_unit import olcu_pkg::*; #(
    parameter int GRID_SIDE      = 256,
    parameter int LOG_ODDS_BITS  = 16,
    parameter int HIT_COUNT_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  olcu_in_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output olcu_out_t              m_data
);

    logic clearing;
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    olcu_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    olcu_back #(
        .GRID_SIDE      (GRID_SIDE),
        .LOG_ODDS_BITS  (LOG_ODDS_BITS),
        .HIT_COUNT_BITS (HIT_COUNT_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### sv/olcu_checker.sv
// Port-level checks for the log-odds occupancy cell update unit, bound to the top level.
// Depends on olcu_pkg and occupancy_log_odds_cell_update_unit.
module olcu_checker import olcu_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input olcu_out_t m_data
);

    // The store is being cleared right after reset, so nothing is taken or offered.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("request taken or result offered right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // A result without a stored cell carries no cell contents.
    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.cell_present |->
            !m_data.cell_confirmed && !m_data.obstacle_flag
            && (m_data.cell_log_odds == 16'sd0) && (m_data.cell_hits == 8'd0))
        else $error("absent cell reported with contents");

    a_removed_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.cell_removed |-> !m_data.cell_present)
        else $error("removed cell reported as present");

    a_confirm_obstacle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.cell_confirmed |->
            m_data.cell_present && m_data.obstacle_flag && (m_data.cell_hits != 8'd0))
        else $error("confirmed cell without presence, obstacle flag or hits");

endmodule

bind occupancy_log_odds_cell_update_unit olcu_checker u_checker (.*);
